// ----- sv/midi_cc_to_sysex_mapper_top_macros.svh -----
// -----------------------------------------------------------------------------
// MIDI CC mapper assertion macros
// Shorthands for the concurrent checks in the mapper's modules. Each use
// expects a clock named clk and a synchronous reset named rst in scope.
// -----------------------------------------------------------------------------
`ifndef MIDI_CC_TO_SYSEX_MAPPER_TOP_MACROS_SVH
`define MIDI_CC_TO_SYSEX_MAPPER_TOP_MACROS_SVH

// Condition holds in the same cycle as the trigger.
`define MCSM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Condition holds in the cycle after the trigger.
`define MCSM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/mcsm_pkg.sv -----
// -----------------------------------------------------------------------------
// MIDI CC mapper package
// Widths, message bytes, codes and the command and status bundles shared by
// the controller and the datapath.
// -----------------------------------------------------------------------------
package mcsm_pkg;

  // Default table geometry
  localparam int CONTROLLER_COUNT_DEF = 256;
  localparam int PAGE_SLOTS_DEF       = 8;

  // Field and port widths
  localparam int BYTE_W      = 8;
  localparam int ACTION_W    = 2;
  localparam int PAGE_W      = 3;
  localparam int CHAN_W      = 4;
  localparam int PCOUNT_W    = 4;
  localparam int CFG_INDEX_W = 1;
  localparam int IN_DATA_W   = 32;
  localparam int OUT_DATA_W  = 8;
  localparam int EMIT_IDX_W  = 3;
  localparam int DIVISOR_W   = 7;
  localparam int THRESH_W    = 10;
  localparam int PROD_W      = 16;
  localparam int QUO_W       = 10;
  localparam int SCALED_W    = 26;

  // Division of the scaled value by 127: reciprocal 516 / 2^16, then one correction
  localparam logic [QUO_W-1:0]  RECIP_127   = 10'd516;
  localparam int                RECIP_SHIFT = 16;
  localparam logic [PROD_W-1:0] VALUE_FULL  = 16'd127;

  // Message bytes
  localparam logic [BYTE_W-1:0] CC_STATUS      = 8'hB0;
  localparam logic [BYTE_W-1:0] MAP_PAGE       = 8'hFF;
  localparam logic [BYTE_W-1:0] MAP_SAVE       = 8'hFE;
  localparam logic [BYTE_W-1:0] MAP_THRU       = 8'hFD;
  localparam logic [BYTE_W-1:0] PARAM_BANK_BIT = 8'h80;
  localparam logic [BYTE_W-1:0] SYX_GROUP_HI   = 8'h13;
  localparam logic [BYTE_W-1:0] SYX_GROUP_LO   = 8'h12;
  localparam logic [BYTE_W-1:0] SYX_START      = 8'hF0;
  localparam logic [BYTE_W-1:0] SYX_MAKER      = 8'h43;
  localparam logic [BYTE_W-1:0] SYX_CHAN       = 8'h10;
  localparam logic [BYTE_W-1:0] SYX_END        = 8'hF7;
  localparam logic [BYTE_W-1:0] MASK_RESET     = 8'h7F;
  localparam logic [BYTE_W-1:0] MAP_RESET      = MAP_THRU;

  // Item kinds
  localparam logic [ACTION_W-1:0] ACT_MIDI = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_MAP  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_MASK = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_MIDI_CHANNEL = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PAGE_COUNT   = 1'd1;

  localparam logic [CHAN_W-1:0]   MIDI_CHANNEL_RESET = 4'd0;
  localparam logic [PCOUNT_W-1:0] PAGE_COUNT_RESET   = 4'd3;

  // Kind of message being sent out
  typedef enum logic [1:0] {
    EMIT_PASS,
    EMIT_CC,
    EMIT_SYSEX
  } emit_kind_t;

  // Meaning of a map table entry
  typedef enum logic [1:0] {
    MAP_KIND_PAGE,
    MAP_KIND_SAVE,
    MAP_KIND_THRU,
    MAP_KIND_PARAM
  } map_kind_t;

  // Controller to datapath
  typedef struct packed {
    logic                  latch_in;
    logic                  clear_step;
    logic                  wr_map;
    logic                  wr_mask;
    logic                  hold_ctrl;
    logic                  latch_lookup;
    logic                  set_page;
    logic                  out_load;
    emit_kind_t            out_kind;
    logic [EMIT_IDX_W-1:0] out_idx;
    logic                  out_last;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic                byte_is_status;
    logic                page_ok;
    map_kind_t           map_kind;
    logic                clear_last;
  } status_t;

  // Number of bytes in each outgoing message
  function automatic logic [EMIT_IDX_W-1:0] emit_count(input emit_kind_t kind);
    logic [EMIT_IDX_W-1:0] n;
    case (kind)
      EMIT_PASS:  n = 3'd1;
      EMIT_CC:    n = 3'd3;
      EMIT_SYSEX: n = 3'd7;
      default:    n = 3'd1;
    endcase
    return n;
  endfunction

  // Page slot width 127 / page_count, a page count of zero counting as one
  function automatic logic [DIVISOR_W-1:0] page_divisor(input logic [PCOUNT_W-1:0] pc);
    logic [DIVISOR_W-1:0] d;
    case (pc)
      4'd0:    d = 7'd127;
      4'd1:    d = 7'd127;
      4'd2:    d = 7'd63;
      4'd3:    d = 7'd42;
      4'd4:    d = 7'd31;
      4'd5:    d = 7'd25;
      4'd6:    d = 7'd21;
      4'd7:    d = 7'd18;
      4'd8:    d = 7'd15;
      4'd9:    d = 7'd14;
      4'd10:   d = 7'd12;
      4'd11:   d = 7'd11;
      4'd12:   d = 7'd10;
      4'd13:   d = 7'd9;
      4'd14:   d = 7'd9;
      4'd15:   d = 7'd8;
      default: d = 7'd127;
    endcase
    return d;
  endfunction

endpackage

// ----- sv/midi_cc_to_sysex_mapper_top.sv -----
// -----------------------------------------------------------------------------
// MIDI CC to parameter-change sysex mapper
// Passes a MIDI byte stream through and rewrites control-change messages on
// the selected channel into seven-byte parameter-change sysex messages.
// -----------------------------------------------------------------------------
// After reset the block sweeps both tables to their reset contents, one entry
// per cycle, over all CONTROLLER_COUNT * PAGE_SLOTS entries (2048 at the
// defaults); s_axis_tready stays low during that sweep while configuration
// writes are taken. Then one item is handled at a time: a load item, an
// ignored item, or the status or controller byte of a control change is
// accepted and decoded, a passed-through byte is then also emitted, and the
// value byte of a control change goes on to the registered table read and then
// to one emit step per byte sent through the one-byte output register: none
// for a page select or a save request, three for a re-sent CC and seven for a
// sysex message. The next item is accepted while the final byte of the
// previous one still waits in the output register.
module midi_cc_to_sysex_mapper_top #(
  parameter int CONTROLLER_COUNT = mcsm_pkg::CONTROLLER_COUNT_DEF,
  parameter int PAGE_SLOTS       = mcsm_pkg::PAGE_SLOTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // Input items
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // midi_byte [7:0], entry_controller [15:8], entry_page [18:16],
  // entry_value [26:19], zero [31:27]
  input  logic [mcsm_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // action [1:0]
  input  logic [mcsm_pkg::ACTION_W-1:0]    s_axis_tuser,
  // Result bytes
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // out_byte [7:0]
  output logic [mcsm_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  output logic                             m_axis_tlast,
  // Configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mcsm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mcsm_pkg::CHAN_W-1:0]      cfg_data
);

  import mcsm_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Registers are always writable
  assign cfg_ready = 1'b1;

  mcsm_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .status        (status),
    .cmd           (cmd)
  );

  mcsm_dp #(
    .CONTROLLER_COUNT (CONTROLLER_COUNT),
    .PAGE_SLOTS       (PAGE_SLOTS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .status       (status)
  );

endmodule

// ----- sv/mcsm_ram.sv -----
// -----------------------------------------------------------------------------
// MIDI CC mapper table RAM
// Simple dual-port memory: one write port, one read port with registered data.
// -----------------------------------------------------------------------------
module mcsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/mcsm_dp.sv -----
// -----------------------------------------------------------------------------
// MIDI CC mapper datapath
// Holds the accepted item, configuration, controller and page registers, the
// map and mask tables, the page and scaling arithmetic and the output register.
// -----------------------------------------------------------------------------
module mcsm_dp #(
  parameter int CONTROLLER_COUNT = mcsm_pkg::CONTROLLER_COUNT_DEF,
  parameter int PAGE_SLOTS       = mcsm_pkg::PAGE_SLOTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [mcsm_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  input  logic [mcsm_pkg::ACTION_W-1:0]      s_axis_tuser,
  output logic [mcsm_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  output logic                               m_axis_tlast,
  input  logic                               cfg_valid,
  input  logic [mcsm_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [mcsm_pkg::CHAN_W-1:0]        cfg_data,
  input  mcsm_pkg::cmd_t                     cmd,
  output mcsm_pkg::status_t                  status
);

  import mcsm_pkg::*;

  localparam int DEPTH = CONTROLLER_COUNT * PAGE_SLOTS;
  localparam int IDX_W = $clog2(DEPTH);

  // Latched item
  logic [ACTION_W-1:0] in_action;
  logic [BYTE_W-1:0]   in_byte;
  logic [BYTE_W-1:0]   in_ctrl;
  logic [PAGE_W-1:0]   in_page;
  logic [BYTE_W-1:0]   in_value;

  // Architectural registers
  logic [CHAN_W-1:0]   midi_channel;
  logic [PCOUNT_W-1:0] page_count;
  logic [BYTE_W-1:0]   held_ctrl;
  logic [PAGE_W-1:0]   current_page;
  logic [IDX_W-1:0]    clr_addr;

  // Lookup and arithmetic
  logic [BYTE_W-1:0]    map_rd;
  logic [BYTE_W-1:0]    mask_rd;
  logic [BYTE_W-1:0]    map_q;
  logic [PROD_W-1:0]    prod;
  logic [PROD_W-1:0]    prod_d;
  logic [SCALED_W-1:0]  scaled;
  logic [QUO_W-1:0]     quo_est;
  logic [PROD_W-1:0]    rem;
  logic [BYTE_W-1:0]    scaled_value;
  logic [DIVISOR_W-1:0] divisor;
  logic [PAGE_W-1:0]    page_calc;

  // Table addressing
  logic [BYTE_W-1:0] entry_ctrl_m;
  logic [BYTE_W-1:0] held_ctrl_m;
  logic [IDX_W-1:0]  entry_idx;
  logic [IDX_W-1:0]  lookup_idx;
  logic              map_we;
  logic              mask_we;
  logic [IDX_W-1:0]  waddr;
  logic [BYTE_W-1:0] map_wdata;
  logic [BYTE_W-1:0] mask_wdata;

  logic [BYTE_W-1:0] status_byte;
  logic [BYTE_W-1:0] emit_byte;

  // Item register
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      in_action <= s_axis_tuser;
      in_byte   <= s_axis_tdata[7:0];
      in_ctrl   <= s_axis_tdata[15:8];
      in_page   <= s_axis_tdata[18:16];
      in_value  <= s_axis_tdata[26:19];
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      midi_channel <= MIDI_CHANNEL_RESET;
      page_count   <= PAGE_COUNT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MIDI_CHANNEL: midi_channel <= cfg_data;
        CFG_PAGE_COUNT:   page_count   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Held controller, current page and clearing address
  always_ff @(posedge clk) begin
    if (rst) begin
      held_ctrl    <= '0;
      current_page <= '0;
      clr_addr     <= '0;
    end else begin
      if (cmd.hold_ctrl) begin
        held_ctrl <= in_byte;
      end
      if (cmd.set_page) begin
        current_page <= page_calc;
      end
      if (cmd.clear_step) begin
        clr_addr <= clr_addr + IDX_W'(1);
      end
    end
  end

  // Controller numbers wrap at the table's controller count
  always_comb begin
    entry_ctrl_m = ({1'b0, in_ctrl} >= 9'(CONTROLLER_COUNT)) ?
                   8'({1'b0, in_ctrl} - 9'(CONTROLLER_COUNT)) : in_ctrl;
    held_ctrl_m  = ({1'b0, held_ctrl} >= 9'(CONTROLLER_COUNT)) ?
                   8'({1'b0, held_ctrl} - 9'(CONTROLLER_COUNT)) : held_ctrl;
    entry_idx    = IDX_W'(int'(entry_ctrl_m) * PAGE_SLOTS + int'(in_page));
    lookup_idx   = IDX_W'(int'(held_ctrl_m) * PAGE_SLOTS + int'(current_page));
  end

  // Write port: the clearing pass after reset, or a load item
  always_comb begin
    if (cmd.clear_step) begin
      waddr      = clr_addr;
      map_wdata  = MAP_RESET;
      mask_wdata = MASK_RESET;
      map_we     = 1'b1;
      mask_we    = 1'b1;
    end else begin
      waddr      = entry_idx;
      map_wdata  = in_value;
      mask_wdata = in_value;
      map_we     = cmd.wr_map;
      mask_we    = cmd.wr_mask;
    end
  end

  mcsm_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (waddr),
    .wdata (map_wdata),
    .raddr (lookup_idx),
    .rdata (map_rd)
  );

  mcsm_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_mask_ram (
    .clk   (clk),
    .we    (mask_we),
    .waddr (waddr),
    .wdata (mask_wdata),
    .raddr (lookup_idx),
    .rdata (mask_rd)
  );

  // Page select: count the slot boundaries at or below the value, which is
  // the quotient by the slot width capped at PAGE_SLOTS - 1.
  always_comb begin
    divisor   = page_divisor(page_count);
    page_calc = '0;
    for (int k = 1; k < PAGE_SLOTS; k++) begin
      if ({2'b00, in_byte} >= THRESH_W'(k) * THRESH_W'(divisor)) begin
        page_calc = page_calc + PAGE_W'(1);
      end
    end
  end

  // Lookup capture: map entry and value times mask
  always_ff @(posedge clk) begin
    if (cmd.latch_lookup) begin
      map_q <= map_rd;
      prod  <= in_byte * mask_rd;
    end
  end

  // Divide by 127: reciprocal estimate, then one correction step
  assign scaled = SCALED_W'(prod) * SCALED_W'(RECIP_127);
  assign rem    = prod_d - (PROD_W'({quo_est, 7'b0}) - PROD_W'(quo_est));

  always_ff @(posedge clk) begin
    quo_est      <= scaled[RECIP_SHIFT +: QUO_W];
    prod_d       <= prod;
    scaled_value <= (rem >= VALUE_FULL) ? 8'(quo_est + QUO_W'(1)) : 8'(quo_est);
  end

  // Byte for the current slot of the outgoing message
  assign status_byte = CC_STATUS + {4'h0, midi_channel};

  always_comb begin
    emit_byte = in_byte;
    case (cmd.out_kind)
      EMIT_PASS: emit_byte = in_byte;
      EMIT_CC: begin
        case (cmd.out_idx)
          3'd0:    emit_byte = status_byte;
          3'd1:    emit_byte = held_ctrl;
          default: emit_byte = in_byte;
        endcase
      end
      EMIT_SYSEX: begin
        case (cmd.out_idx)
          3'd0:    emit_byte = SYX_START;
          3'd1:    emit_byte = SYX_MAKER;
          3'd2:    emit_byte = SYX_CHAN + {4'h0, midi_channel};
          3'd3:    emit_byte = ((map_q & PARAM_BANK_BIT) != 8'h00) ?
                               SYX_GROUP_HI : SYX_GROUP_LO;
          3'd4:    emit_byte = map_q;
          3'd5:    emit_byte = scaled_value;
          default: emit_byte = SYX_END;
        endcase
      end
      default: emit_byte = in_byte;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_axis_tdata <= emit_byte;
      m_axis_tlast <= cmd.out_last;
    end
  end

  // Status back to the controller
  always_comb begin
    status.action         = in_action;
    status.byte_is_status = (in_byte == status_byte);
    status.page_ok        = (int'(in_page) < PAGE_SLOTS);
    status.clear_last     = (clr_addr == IDX_W'(DEPTH - 1));
    case (map_rd)
      MAP_PAGE: status.map_kind = MAP_KIND_PAGE;
      MAP_SAVE: status.map_kind = MAP_KIND_SAVE;
      MAP_THRU: status.map_kind = MAP_KIND_THRU;
      default:  status.map_kind = MAP_KIND_PARAM;
    endcase
  end

endmodule

// ----- sv/mcsm_ctrl.sv -----
// -----------------------------------------------------------------------------
// MIDI CC mapper controller
// Sequences the clearing pass, item decode, table lookup and byte emission,
// and tracks where the MIDI parser stands within a control-change message.
// -----------------------------------------------------------------------------
`include "midi_cc_to_sysex_mapper_top_macros.svh"

module mcsm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  input  mcsm_pkg::status_t status,
  output mcsm_pkg::cmd_t    cmd
);

  import mcsm_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_LOOKUP,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    PH_STATUS,
    PH_CTRL,
    PH_VALUE
  } phase_t;

  state_t                state;
  state_t                state_next;
  phase_t                phase;
  phase_t                phase_next;
  emit_kind_t            emit_kind;
  emit_kind_t            emit_kind_next;
  logic [EMIT_IDX_W-1:0] emit_idx;
  logic [EMIT_IDX_W-1:0] emit_idx_next;
  logic                  out_valid;
  logic                  out_valid_next;

  // Next state and commands
  always_comb begin
    state_next     = state;
    phase_next     = phase;
    emit_kind_next = emit_kind;
    emit_idx_next  = emit_idx;
    out_valid_next = out_valid && !m_axis_tready;
    cmd            = '0;
    cmd.out_kind   = emit_kind;
    cmd.out_idx    = emit_idx;
    cmd.out_last   = (emit_idx == emit_count(emit_kind) - 3'd1);

    case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_last) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (s_axis_tvalid) begin
          cmd.latch_in = 1'b1;
          state_next   = ST_DECODE;
        end
      end

      ST_DECODE: begin
        state_next = ST_IDLE;
        case (status.action)
          ACT_MAP:  cmd.wr_map  = status.page_ok;
          ACT_MASK: cmd.wr_mask = status.page_ok;
          ACT_MIDI: begin
            case (phase)
              PH_STATUS: begin
                if (status.byte_is_status) begin
                  phase_next = PH_CTRL;
                end else begin
                  emit_kind_next = EMIT_PASS;
                  emit_idx_next  = '0;
                  state_next     = ST_EMIT;
                end
              end
              PH_CTRL: begin
                cmd.hold_ctrl = 1'b1;
                phase_next    = PH_VALUE;
              end
              PH_VALUE: begin
                phase_next = PH_STATUS;
                state_next = ST_LOOKUP;
              end
              default: phase_next = PH_STATUS;
            endcase
          end
          default: ;
        endcase
      end

      ST_LOOKUP: begin
        cmd.latch_lookup = 1'b1;
        state_next       = ST_IDLE;
        case (status.map_kind)
          MAP_KIND_PAGE: cmd.set_page = 1'b1;
          MAP_KIND_SAVE: ;
          MAP_KIND_THRU: begin
            emit_kind_next = EMIT_CC;
            emit_idx_next  = '0;
            state_next     = ST_EMIT;
          end
          MAP_KIND_PARAM: begin
            emit_kind_next = EMIT_SYSEX;
            emit_idx_next  = '0;
            state_next     = ST_EMIT;
          end
          default: ;
        endcase
      end

      ST_EMIT: begin
        // One byte per cycle whenever the output register is free
        if (!out_valid || m_axis_tready) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          if (cmd.out_last) begin
            state_next = ST_IDLE;
          end else begin
            emit_idx_next = emit_idx + 3'd1;
          end
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      phase     <= PH_STATUS;
      emit_kind <= EMIT_PASS;
      emit_idx  <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      phase     <= phase_next;
      emit_kind <= emit_kind_next;
      emit_idx  <= emit_idx_next;
      out_valid <= out_valid_next;
    end
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;

  // Checks
  `MCSM_ASSERT_IMP(a_no_overwrite, cmd.out_load, !out_valid || m_axis_tready,
                   "result beat overwritten before it was taken")
  `MCSM_ASSERT_IMP(a_idx_in_range, state == ST_EMIT, emit_idx < emit_count(emit_kind),
                   "emit index beyond message length")
  `MCSM_ASSERT_NXT(a_last_frees, cmd.out_load && cmd.out_last, state == ST_IDLE,
                   "controller did not return to idle after the final beat")
  `MCSM_ASSERT_IMP(a_clear_blocks, state == ST_CLEAR, !s_axis_tready,
                   "item accepted during the table clearing pass")

endmodule
